// ===== hdl/tpi_pkg.sv =====
// tpi_pkg: shared types, widths and codes for the thrust profile interpolator.
// No dependencies; compiled first.

package tpi_pkg;

  localparam int TPI_DEPTH_DEF = 256;   // default row count of the table

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int TIME_W   = 32;
  localparam int FORCE_W  = 32;
  localparam int FRAC_W   = 16;          // Q0.16 interpolation fraction
  localparam int QUO_W    = FRAC_W + 1;  // fraction can reach exactly 1.0
  localparam int DIFF_W   = FORCE_W + 1;
  localparam int PROD_W   = QUO_W + 1 + DIFF_W;

  localparam logic [QUO_W-1:0] FRAC_ONE = QUO_W'(1) << FRAC_W;

  // command codes; the high bit alone selects a query
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_STORED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INTERP  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLAMPED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FEW     = 3'd5;

  typedef struct packed {
    logic [TIME_W-1:0]  tm;
    logic [FORCE_W-1:0] fx;
    logic [FORCE_W-1:0] fy;
    logic [FORCE_W-1:0] fz;
  } row_t;

endpackage

// ===== hdl/tpi_if.sv =====
// tpi_if: valid/ready channel interfaces for command input and result output.
// Depends on tpi_pkg.

interface tpi_in_if import tpi_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic [TIME_W-1:0]         sample_time;
  logic signed [FORCE_W-1:0] in_force_x;
  logic signed [FORCE_W-1:0] in_force_y;
  logic signed [FORCE_W-1:0] in_force_z;

  modport source (output valid, cmd, sample_time, in_force_x, in_force_y, in_force_z,
                  input ready);
  modport sink   (input valid, cmd, sample_time, in_force_x, in_force_y, in_force_z,
                  output ready);
endinterface

interface tpi_out_if import tpi_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [FORCE_W-1:0] out_force_x;
  logic signed [FORCE_W-1:0] out_force_y;
  logic signed [FORCE_W-1:0] out_force_z;

  modport source (output valid, status, out_force_x, out_force_y, out_force_z,
                  input ready);
  modport sink   (input valid, status, out_force_x, out_force_y, out_force_z,
                  output ready);
endinterface

// ===== hdl/thrust_profile_interpolator.sv =====
// thrust_profile_interpolator: piecewise linear force table with sequential query engine.
// Depends on tpi_pkg and the channel interfaces in tpi_if.sv.
//
//  channel   | dir | modport | payload
//  ----------+-----+---------+-----------------------------------------------------
//  in_ch     | in  | sink    | cmd, sample_time, in_force_x/y/z
//  out_ch    | out | source  | status, out_force_x/y/z
//
// Flow: clear, append and a query on fewer than two rows go from transfer to load;
// a clamped query reads the first row and, unless clamped there, the last row; an
// interpolated query searches rows 1..n-1 with one table read per search step, runs
// 17 shared compare-subtract steps, then one multiplier and one add per axis.
// Reset clears state, row count and output valid; table rows are undefined until appended.
// Stalls: a waiting result sits in the output register and the next command is still
// taken; the engine only holds in its load cycle while that register is full.

module thrust_profile_interpolator
  import tpi_pkg::*;
#(
  parameter int TABLE_DEPTH = TPI_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tpi_in_if.sink    in_ch,
  tpi_out_if.source out_ch
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int STEP_W = $clog2(QUO_W);

  typedef enum logic [2:0] {
    S_IDLE, S_FIRST, S_LAST, S_SRCH, S_DIV, S_MUL, S_ADD, S_PUSH
  } state_t;

  function automatic logic [FORCE_W-1:0] lane_force(row_t r, logic [1:0] lane);
    logic [FORCE_W-1:0] f;
    case (lane)
      2'd0:    f = r.fx;
      2'd1:    f = r.fy;
      default: f = r.fz;
    endcase
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t                     state_r, state_nxt;
  logic [CNT_W-1:0]           rows_r, rows_nxt;       // rows held
  logic [IDX_W-1:0]           idx_r, idx_nxt;         // row under read
  logic [TIME_W-1:0]          t_r, t_nxt;             // query time
  row_t                       prev_r, prev_nxt;       // row idx-1 during search
  logic [TIME_W-1:0]          rem_r, rem_nxt;         // divider remainder
  logic [TIME_W-1:0]          d_r, d_nxt;             // divisor
  logic [QUO_W-1:0]           q_r, q_nxt;             // quotient / fraction
  logic [STEP_W-1:0]          step_r, step_nxt;       // divider step
  logic [1:0]                 lane_r, lane_nxt;       // axis under multiply
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic [FORCE_W-1:0]         f0_r, f0_nxt;
  logic [STATUS_W-1:0]        res_st_r, res_st_nxt;
  logic [FORCE_W-1:0]         res_f_r [3];
  logic [FORCE_W-1:0]         res_f_nxt [3];
  logic                       out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]        out_st_r, out_st_nxt;
  logic [FORCE_W-1:0]         out_f_r [3];
  logic [FORCE_W-1:0]         out_f_nxt [3];

  // ---------------------------------------------------------------------------
  // Row table: one write port (append), one registered read port
  // ---------------------------------------------------------------------------
  row_t             mem [TABLE_DEPTH];
  row_t             rd_r;
  logic             wr_en;
  row_t             wr_row;

  assign wr_row = '{tm: in_ch.sample_time, fx: in_ch.in_force_x,
                    fy: in_ch.in_force_y,  fz: in_ch.in_force_z};

  // read address is the next index, so rd_r always holds row idx_r
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[rows_r[IDX_W-1:0]] <= wr_row;
    end
    rd_r <= mem[idx_nxt];
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic                     in_xfer;
  logic                     full;
  logic [IDX_W-1:0]         last_idx;
  logic [TIME_W:0]          div_trial;
  logic                     div_ge;
  logic [QUO_W-1:0]         frac;
  logic signed [DIFF_W-1:0] diff;
  logic signed [QUO_W:0]    frac_s;
  logic [FORCE_W-1:0]       f0_sel;
  logic [FORCE_W-1:0]       f1_sel;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign full        = (rows_r >= CNT_W'(TABLE_DEPTH));
  assign last_idx    = IDX_W'(rows_r - CNT_W'(1));

  // shared compare-subtract: first step compares the raw offset (fraction bit 16)
  assign div_trial = (step_r == '0) ? {1'b0, rem_r} : {rem_r, 1'b0};
  assign div_ge    = (div_trial >= {1'b0, d_r});

  // fraction never exceeds 1.0 for a well-formed segment; clamp regardless
  assign frac   = (q_r > FRAC_ONE) ? FRAC_ONE : q_r;
  assign frac_s = $signed({1'b0, frac});
  assign f0_sel = lane_force(prev_r, lane_r);
  assign f1_sel = lane_force(rd_r, lane_r);
  assign diff   = $signed({f1_sel[FORCE_W-1], f1_sel}) - $signed({f0_sel[FORCE_W-1], f0_sel});

  always_comb begin
    state_nxt     = state_r;
    rows_nxt      = rows_r;
    idx_nxt       = idx_r;
    t_nxt         = t_r;
    prev_nxt      = prev_r;
    rem_nxt       = rem_r;
    d_nxt         = d_r;
    q_nxt         = q_r;
    step_nxt      = step_r;
    lane_nxt      = lane_r;
    prod_nxt      = prod_r;
    f0_nxt        = f0_r;
    res_st_nxt    = res_st_r;
    res_f_nxt     = res_f_r;
    out_st_nxt    = out_st_r;
    out_f_nxt     = out_f_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    wr_en         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          t_nxt     = in_ch.sample_time;
          res_f_nxt = '{default: '0};
          state_nxt = S_PUSH;
          if (in_ch.cmd == CMD_CLEAR) begin
            rows_nxt   = '0;
            res_st_nxt = ST_CLEARED;
          end else if (in_ch.cmd == CMD_APPEND) begin
            if (full) begin
              res_st_nxt = ST_FULL;
            end else begin
              wr_en      = 1'b1;
              rows_nxt   = rows_r + CNT_W'(1);
              res_st_nxt = ST_STORED;
            end
          end else if (rows_r < CNT_W'(2)) begin
            res_st_nxt = ST_FEW;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_FIRST;
          end
        end
      end

      S_FIRST: begin
        prev_nxt = rd_r;
        if (t_r <= rd_r.tm) begin
          res_st_nxt = ST_CLAMPED;
          res_f_nxt  = '{rd_r.fx, rd_r.fy, rd_r.fz};
          state_nxt  = S_PUSH;
        end else begin
          idx_nxt   = last_idx;
          state_nxt = S_LAST;
        end
      end

      S_LAST: begin
        if (t_r >= rd_r.tm) begin
          res_st_nxt = ST_CLAMPED;
          res_f_nxt  = '{rd_r.fx, rd_r.fy, rd_r.fz};
          state_nxt  = S_PUSH;
        end else begin
          idx_nxt   = IDX_W'(1);
          state_nxt = S_SRCH;
        end
      end

      // stop at the first row not below t, or at the last row
      S_SRCH: begin
        if ((idx_r == last_idx) || (t_r <= rd_r.tm)) begin
          rem_nxt   = t_r - prev_r.tm;
          d_nxt     = (rd_r.tm > prev_r.tm) ? (rd_r.tm - prev_r.tm) : TIME_W'(1);
          q_nxt     = '0;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end else begin
          prev_nxt = rd_r;
          idx_nxt  = idx_r + IDX_W'(1);
        end
      end

      S_DIV: begin
        rem_nxt  = div_ge ? TIME_W'(div_trial - {1'b0, d_r}) : TIME_W'(div_trial);
        q_nxt    = {q_r[QUO_W-2:0], div_ge};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(QUO_W - 1)) begin
          lane_nxt  = 2'd0;
          state_nxt = S_MUL;
        end
      end

      S_MUL: begin
        prod_nxt  = PROD_W'(frac_s * diff);
        f0_nxt    = f0_sel;
        state_nxt = S_ADD;
      end

      // arithmetic shift of the product floors toward minus infinity
      S_ADD: begin
        res_f_nxt[lane_r] = f0_r + prod_r[FRAC_W +: FORCE_W];
        res_st_nxt        = ST_INTERP;
        if (lane_r == 2'd2) begin
          state_nxt = S_PUSH;
        end else begin
          lane_nxt  = lane_r + 2'd1;
          state_nxt = S_MUL;
        end
      end

      S_PUSH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_f_nxt     = res_f_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rows_r      <= rows_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r    <= idx_nxt;
    t_r      <= t_nxt;
    prev_r   <= prev_nxt;
    rem_r    <= rem_nxt;
    d_r      <= d_nxt;
    q_r      <= q_nxt;
    step_r   <= step_nxt;
    lane_r   <= lane_nxt;
    prod_r   <= prod_nxt;
    f0_r     <= f0_nxt;
    res_st_r <= res_st_nxt;
    res_f_r  <= res_f_nxt;
    out_st_r <= out_st_nxt;
    out_f_r  <= out_f_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_st_r;
  assign out_ch.out_force_x = out_f_r[0];
  assign out_ch.out_force_y = out_f_r[1];
  assign out_ch.out_force_z = out_f_r[2];

endmodule

// ===== tb/thrust_table_checker.sv =====
// thrust_table_checker: watches both channels of the thrust profile interpolator,
// keeps its own copy of the force table and compares every result transfer.
// Depends on tpi_pkg and the channel interfaces in tpi_if.sv.

module thrust_table_checker
  import tpi_pkg::*;
#(
  parameter int DEPTH = TPI_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  tpi_in_if    in_ch,
  tpi_out_if   out_ch,
  output int   mismatch_count,
  output int   forces_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FORCE_W-1:0]  fx;
    logic [FORCE_W-1:0]  fy;
    logic [FORCE_W-1:0]  fz;
  } force_result_t;

  row_t          tbl_rows [DEPTH];
  int unsigned   tbl_count;
  force_result_t expected_forces [$];

  initial begin
    mismatch_count     = 0;
    forces_outstanding = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // f0 + floor(frac * (f1 - f0) / 2^16); >>> on a signed value floors
  function automatic logic [FORCE_W-1:0] lerp_axis(input logic [FORCE_W-1:0] a, b,
                                                    input longint frac);
    longint base, slope;
    base  = longint'(signed'(a));
    slope = longint'(signed'(b)) - base;
    return FORCE_W'(base + ((frac * slope) >>> FRAC_W));
  endfunction

  function automatic force_result_t row_result(input row_t r, input logic [STATUS_W-1:0] st);
    force_result_t res;
    res.status = st;
    res.fx     = r.fx;
    res.fy     = r.fy;
    res.fz     = r.fz;
    return res;
  endfunction

  // response of the table to one command; updates the table copy
  function automatic force_result_t table_response(input logic [CMD_W-1:0] cmd,
                                                   input row_t item);
    force_result_t     res;
    row_t              lo, hi;
    int unsigned       idx;
    logic [TIME_W-1:0] t, offset, span;
    longint            frac;
    res = '0;
    t   = item.tm;
    case (cmd)
      CMD_CLEAR: begin
        tbl_count  = 0;
        res.status = ST_CLEARED;
      end
      CMD_APPEND: begin
        if (tbl_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          tbl_rows[tbl_count] = item;
          tbl_count++;
          res.status = ST_STORED;
        end
      end
      default: begin  // high command bit set: query
        if (tbl_count < 2) begin
          res.status = ST_FEW;
        end else if (t <= tbl_rows[0].tm) begin
          res = row_result(tbl_rows[0], ST_CLAMPED);
        end else if (t >= tbl_rows[tbl_count-1].tm) begin
          res = row_result(tbl_rows[tbl_count-1], ST_CLAMPED);
        end else begin
          idx = 1;
          while (idx < tbl_count - 1 && t > tbl_rows[idx].tm) idx++;
          lo     = tbl_rows[idx-1];
          hi     = tbl_rows[idx];
          span   = (hi.tm > lo.tm) ? hi.tm - lo.tm : TIME_W'(1);
          offset = t - lo.tm;
          frac   = (longint'(offset) << FRAC_W) / longint'(span);
          if (frac > longint'(FRAC_ONE)) frac = longint'(FRAC_ONE);
          res.status = ST_INTERP;
          res.fx     = lerp_axis(lo.fx, hi.fx, frac);
          res.fy     = lerp_axis(lo.fy, hi.fy, frac);
          res.fz     = lerp_axis(lo.fz, hi.fz, frac);
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    force_result_t want;
    row_t          item;
    if (!rst_n) begin
      tbl_count = 0;
      expected_forces.delete();
      forces_outstanding <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_forces.size() == 0) begin
          report_mismatch($sformatf("result status %0d with nothing expected",
                                    out_ch.status));
        end else begin
          want = expected_forces.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d",
                                      out_ch.status, want.status));
          if (out_ch.out_force_x !== want.fx)
            report_mismatch($sformatf("force_x got %h expected %h",
                                      out_ch.out_force_x, want.fx));
          if (out_ch.out_force_y !== want.fy)
            report_mismatch($sformatf("force_y got %h expected %h",
                                      out_ch.out_force_y, want.fy));
          if (out_ch.out_force_z !== want.fz)
            report_mismatch($sformatf("force_z got %h expected %h",
                                      out_ch.out_force_z, want.fz));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        item.tm = in_ch.sample_time;
        item.fx = in_ch.in_force_x;
        item.fy = in_ch.in_force_y;
        item.fz = in_ch.in_force_z;
        expected_forces.insert(expected_forces.size(), table_response(in_ch.cmd, item));
      end
      forces_outstanding <= expected_forces.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// tb_top: stimulus and verdict for the thrust profile interpolator.
// Depends on tpi_pkg, tpi_if.sv, the block and thrust_table_checker.

module tb_top;
  import tpi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // query encodings: the block decodes any command with the high bit set as a query
  localparam logic [CMD_W-1:0] CMD_QUERY    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY_HI = 2'd3;

  localparam logic [FORCE_W-1:0] F_MIN = 32'h8000_0000;
  localparam logic [FORCE_W-1:0] F_MAX = 32'h7FFF_FFFF;
  localparam logic [TIME_W-1:0]  T_MAX = 32'hFFFF_FFFF;

  localparam int RESET_CYCLES = 11;
  localparam int IDLE_PCT     = 21;     // percent of cycles a side sits idle
  localparam int ITEM_TARGET  = 2000;
  localparam int HOLD_CYCLES  = 600;    // long output back-pressure stretch
  localparam int DRAIN_TAIL   = 320;    // longer than the slowest query
  localparam int STALL_LIMIT  = 20000;  // cycles without any transfer

  logic clk;
  logic rst_n;

  tpi_in_if  in_ch ();
  tpi_out_if out_ch ();

  int mismatch_count;
  int forces_outstanding;

  bit          calm;       // no idling on either side while set
  bit          hold_req;   // asks the result side for one long hold-off
  int unsigned items_sent;

  // row times appended since the last clear; only used to aim queries
  logic [TIME_W-1:0] prof_times [$];

  thrust_profile_interpolator #(.TABLE_DEPTH(TPI_DEPTH_DEF)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  thrust_table_checker #(.DEPTH(TPI_DEPTH_DEF)) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_ch              (in_ch),
    .out_ch             (out_ch),
    .mismatch_count     (mismatch_count),
    .forces_outstanding (forces_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side: random stalls, none while calm, and one long hold-off per request.
  // The hold-off is counted here, so the sender keeps offering items meanwhile and
  // the block has to fill its output register and stop taking commands.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: a hang shows up as a long run of cycles without any transfer.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // One command transfer. Random idle cycles go in front; valid stays high
  // from one item to the next when no idle cycle falls between them.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] t,
                           input logic [FORCE_W-1:0] fx, fy, fz);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= cmd;
    in_ch.sample_time <= t;
    in_ch.in_force_x  <= fx;
    in_ch.in_force_y  <= fy;
    in_ch.in_force_z  <= fz;
    do @(posedge clk); while (!in_ch.ready);
    if (cmd == CMD_CLEAR) prof_times.delete();
    else if (cmd == CMD_APPEND && prof_times.size() < TPI_DEPTH_DEF)
      prof_times.insert(prof_times.size(), t);
    items_sent++;
  endtask

  task automatic send_query(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] t);
    send_item(cmd, t, $urandom, $urandom, $urandom);
  endtask

  // sender pause until every result is back
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (forces_outstanding != 0);
  endtask

  // forces: full random, small random walk, or the signed extremes
  function automatic logic [FORCE_W-1:0] next_force(input logic [FORCE_W-1:0] prev);
    int unsigned mode;
    mode = $urandom_range(99);
    if (mode < 45) return $urandom;
    if (mode < 85) return prev + FORCE_W'($urandom_range(32'h3_FFFF)) - FORCE_W'(32'h1_FFFF);
    if (mode < 93) return F_MIN;
    return F_MAX;
  endfunction

  // mostly inside an interval of the current table, some on row times or the extremes
  function automatic logic [TIME_W-1:0] pick_query_time();
    int unsigned mode, j;
    mode = $urandom_range(99);
    if (prof_times.size() >= 2 && mode < 70) begin
      j = $urandom_range(prof_times.size() - 2);
      return $urandom_range(prof_times[j+1], prof_times[j]);
    end
    if (prof_times.size() >= 1 && mode < 82) return prof_times[$urandom_range(prof_times.size()-1)];
    if (mode < 90) return ($urandom_range(1) == 1) ? T_MAX : '0;
    return $urandom;
  endfunction

  // Directed opening: empty and single-row tables, both query encodings, the
  // time and force extremes, clamping at both ends, out-of-order rows and
  // rows sharing a time.
  task automatic directed_checks();
    send_query(CMD_QUERY, 32'h0000_1000);              // empty table
    send_item(CMD_APPEND, '0, F_MIN, F_MAX, '0);
    send_query(CMD_QUERY_HI, 32'h0001_0000);           // one row only
    send_item(CMD_APPEND, T_MAX, F_MAX, F_MIN, F_MAX);
    send_query(CMD_QUERY, '0);                         // clamp to first row
    send_query(CMD_QUERY, T_MAX);                      // clamp to last row
    send_query(CMD_QUERY, 32'h8000_0000);              // full-scale slopes
    send_query(CMD_QUERY_HI, 32'h0000_0001);           // fraction near zero
    send_query(CMD_QUERY, T_MAX - 1);                  // fraction near one
    send_item(CMD_CLEAR, T_MAX, F_MAX, F_MAX, F_MAX);
    send_query(CMD_QUERY, 32'h0064_0000);              // too few after clear
    // 100, 300, 300, 200, 400 seconds: shared time and a step backwards
    send_item(CMD_APPEND, 32'h0064_0000, 32'h0005_0000, 32'hFFFB_0000, F_MAX);
    send_item(CMD_APPEND, 32'h012C_0000, 32'hFFFF_8000, 32'h0003_0001, F_MIN);
    send_item(CMD_APPEND, 32'h012C_0000, 32'h0010_0000, 32'h0000_0000, 32'h0000_0007);
    send_item(CMD_APPEND, 32'h00C8_0000, F_MIN, 32'h7FFF_0000, 32'hFFFF_FFFF);
    send_item(CMD_APPEND, 32'h0190_0000, F_MAX, 32'h8001_0000, 32'h0000_0001);
    send_query(CMD_QUERY, 32'h00FA_0000);              // between first two rows
    send_query(CMD_QUERY, 32'h015E_0000);              // search passes the step back
    send_query(CMD_QUERY_HI, 32'h012C_0000);           // exactly on a row time
    send_query(CMD_QUERY, 32'h0064_0000);              // exactly on the first row
    send_item(CMD_CLEAR, '0, '0, '0, '0);
  endtask

  // One profile: usually a clear, a run of appends, then queries against it.
  // Most tables are small to keep queries short; a few overrun the table.
  task automatic run_profile();
    int unsigned       kind, n_rows, n_query, mode;
    logic [TIME_W-1:0] t, step_cap;
    logic [FORCE_W-1:0] fx, fy, fz;
    kind = $urandom_range(99);
    if (kind < 2)       n_rows = $urandom_range(TPI_DEPTH_DEF + 8, TPI_DEPTH_DEF - 4);
    else if (kind < 10) n_rows = $urandom_range(1);
    else                n_rows = $urandom_range(16, 2);
    if ($urandom_range(99) < 90) send_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
    t        = ($urandom_range(3) == 0) ? TIME_W'($urandom_range(255)) : $urandom;
    step_cap = (n_rows > 64) ? 32'h0000_FFFF : (T_MAX >> $urandom_range(31, 4));
    fx = $urandom;
    fy = $urandom;
    fz = $urandom;
    for (int r = 0; r < n_rows; r++) begin
      mode = $urandom_range(99);
      if (r > 0) begin
        if (mode < 8)       t = t;                    // same time as the row before
        else if (mode < 14) t = $urandom;             // likely out of order
        else                t = t + $urandom_range(step_cap, 1);
      end
      fx = next_force(fx);
      fy = next_force(fy);
      fz = next_force(fz);
      send_item(CMD_APPEND, t, fx, fy, fz);
      if ($urandom_range(99) < 3)                     // stray command in the sequence
        send_item(CMD_W'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom);
    end
    n_query = (n_rows > 64) ? 4 : $urandom_range(12, 1);
    repeat (n_query)
      send_query(($urandom_range(99) < 15) ? CMD_QUERY_HI : CMD_QUERY, pick_query_time());
  endtask

  initial begin
    int unsigned prof_idx;
    in_ch.valid       <= 1'b0;
    in_ch.cmd         <= CMD_CLEAR;
    in_ch.sample_time <= '0;
    in_ch.in_force_x  <= '0;
    in_ch.in_force_y  <= '0;
    in_ch.in_force_z  <= '0;
    rst_n             <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    directed_checks();

    prof_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      // two long output hold-offs, one stretch with no idling, and drain pauses
      if (prof_idx == 20 || prof_idx == 70) hold_req = 1'b1;
      calm = (prof_idx >= 40 && prof_idx < 55);
      if (prof_idx == 30 || $urandom_range(99) < 15) wait_drain();
      run_profile();
      prof_idx++;
    end
    calm = 1'b0;

    wait_drain();
    repeat (DRAIN_TAIL) @(posedge clk);   // catch any result nobody asked for
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
